### hdl/c2p_pkg.sv
// Shared constants and the arctangent table of the Cartesian-to-polar converter.
`default_nettype none
package c2p_pkg;

  localparam int COORD_WIDTH   = 16;
  localparam int CORDIC_STEPS  = 16;
  localparam int GUARD_BITS    = 24;
  localparam int TURN_BITS     = 32;
  localparam int ATAN_LEN      = 32;
  localparam int MAG_WIDTH     = 16;
  localparam int HEADING_WIDTH = 16;

  localparam logic [MAG_WIDTH-1:0] MAG_MAX    = 16'hFFFF;
  localparam logic [TURN_BITS-1:0] HALF_TURN  = 32'h8000_0000;
  localparam logic [TURN_BITS-1:0] ROUND_HALF = 32'h0000_8000;

  // Entry i is atan(2^-i) in units of 2^-32 turn, rounded to nearest.
  function automatic logic [TURN_BITS-1:0] atan_turns(input int unsigned idx);
    logic [TURN_BITS-1:0] val;
    case (idx)
      0:  val = 32'd536870912;
      1:  val = 32'd316933406;
      2:  val = 32'd167458907;
      3:  val = 32'd85004756;
      4:  val = 32'd42667331;
      5:  val = 32'd21354465;
      6:  val = 32'd10679838;
      7:  val = 32'd5340245;
      8:  val = 32'd2670163;
      9:  val = 32'd1335087;
      10: val = 32'd667544;
      11: val = 32'd333772;
      12: val = 32'd166886;
      13: val = 32'd83443;
      14: val = 32'd41722;
      15: val = 32'd20861;
      16: val = 32'd10430;
      17: val = 32'd5215;
      18: val = 32'd2608;
      19: val = 32'd1304;
      20: val = 32'd652;
      21: val = 32'd326;
      22: val = 32'd163;
      23: val = 32'd81;
      24: val = 32'd41;
      25: val = 32'd20;
      26: val = 32'd10;
      27: val = 32'd5;
      28: val = 32'd3;
      29: val = 32'd1;
      30: val = 32'd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage
`default_nettype wire

### hdl/c2p_if.sv
// Valid/ready channel interfaces for the input vector and the polar result.
`default_nettype none
interface c2p_vec_if #(
  parameter int W = c2p_pkg::COORD_WIDTH
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] vec_x;
  logic signed [W-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface c2p_polar_if;
  logic                                 valid;
  logic                                 ready;
  logic [c2p_pkg::MAG_WIDTH-1:0]        magnitude;
  logic [c2p_pkg::HEADING_WIDTH-1:0]    heading;

  modport source (output valid, output magnitude, output heading, input ready);
  modport sink   (input valid, input magnitude, input heading, output ready);
endinterface
`default_nettype wire

### hdl/c2p_sqrt.sv
// Pipelined magnitude path: squares, sum, one root bit per stage, rounding.
`default_nettype none
module c2p_sqrt #(
  parameter int W   = c2p_pkg::COORD_WIDTH,
  parameter int PAD = 0
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [W-1:0]             x,
  input  logic signed [W-1:0]             y,
  output logic [c2p_pkg::MAG_WIDTH-1:0]   magnitude
);

  localparam int RW  = W + 1;
  localparam int RAD = 2 * RW;
  localparam int RMW = RW + 2;
  localparam int MW  = (RW + 1 > c2p_pkg::MAG_WIDTH) ? RW + 1 : c2p_pkg::MAG_WIDTH;

  logic [W-1:0]   ax;
  logic [W-1:0]   ay;
  logic [2*W-1:0] sq_x;
  logic [2*W-1:0] sq_y;
  logic [RAD-1:0] rad_s [0:RW];
  logic [RMW-1:0] rem_s [0:RW];
  logic [RW-1:0]  q_s   [0:RW];
  logic [RW:0]    root_up;
  logic [MW-1:0]  root_w;
  logic [c2p_pkg::MAG_WIDTH-1:0] mag_r [0:PAD];

  assign ax = x[W-1] ? $unsigned(-x) : $unsigned(x);
  assign ay = y[W-1] ? $unsigned(-y) : $unsigned(y);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x     <= (2*W)'(ax) * (2*W)'(ax);
      sq_y     <= (2*W)'(ay) * (2*W)'(ay);
      rad_s[0] <= RAD'(sq_x) + RAD'(sq_y);
      rem_s[0] <= '0;
      q_s[0]   <= '0;
    end
  end

  for (genvar k = 0; k < RW; k++) begin : g_root
    logic [RMW-1:0] rem_sh;
    logic [RMW-1:0] trial;

    assign rem_sh = {rem_s[k][RW-1:0], rad_s[k][RAD-1 -: 2]};
    assign trial  = {q_s[k], 2'b01};

    always_ff @(posedge clk) begin
      if (en) begin
        rad_s[k+1] <= rad_s[k] << 2;
        if (rem_sh >= trial) begin
          rem_s[k+1] <= rem_sh - trial;
          q_s[k+1]   <= {q_s[k][RW-2:0], 1'b1};
        end else begin
          rem_s[k+1] <= rem_sh;
          q_s[k+1]   <= {q_s[k][RW-2:0], 1'b0};
        end
      end
    end
  end

  assign root_up = {1'b0, q_s[RW]} + (RW+1)'(rem_s[RW] > {2'b00, q_s[RW]});
  assign root_w  = MW'(root_up);

  always_ff @(posedge clk) begin
    if (en) begin
      if (root_w > MW'(c2p_pkg::MAG_MAX)) begin
        mag_r[0] <= c2p_pkg::MAG_MAX;
      end else begin
        mag_r[0] <= root_w[c2p_pkg::MAG_WIDTH-1:0];
      end
    end
  end

  for (genvar p = 1; p <= PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        mag_r[p] <= mag_r[p-1];
      end
    end
  end

  assign magnitude = mag_r[PAD];

endmodule
`default_nettype wire

### hdl/c2p_cordic.sv
// Pipelined CORDIC vectoring path that produces the heading, one rotation per stage.
`default_nettype none
module c2p_cordic #(
  parameter int W     = c2p_pkg::COORD_WIDTH,
  parameter int STEPS = c2p_pkg::CORDIC_STEPS,
  parameter int PAD   = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [W-1:0]                 x,
  input  logic signed [W-1:0]                 y,
  output logic [c2p_pkg::HEADING_WIDTH-1:0]   heading
);

  localparam int G  = c2p_pkg::GUARD_BITS;
  localparam int CW = W + G + 3;
  localparam int ZW = c2p_pkg::TURN_BITS;

  logic signed [CW-1:0] xe;
  logic signed [CW-1:0] ye;
  logic signed [CW-1:0] x_s [0:STEPS];
  logic signed [CW-1:0] y_s [0:STEPS];
  logic [ZW-1:0]        z_s [0:STEPS];
  logic                 zero_s [0:STEPS];
  logic [ZW-1:0]        z_round;
  logic [c2p_pkg::HEADING_WIDTH-1:0] head_r [0:PAD];

  assign xe = {{(CW-W-G){x[W-1]}}, x, {G{1'b0}}};
  assign ye = {{(CW-W-G){y[W-1]}}, y, {G{1'b0}}};

  // The left half plane is folded over by negating the vector and starting at a half turn.
  always_ff @(posedge clk) begin
    if (en) begin
      zero_s[0] <= (x == '0) && (y == '0);
      if (x[W-1]) begin
        x_s[0] <= -xe;
        y_s[0] <= -ye;
        z_s[0] <= c2p_pkg::HALF_TURN;
      end else begin
        x_s[0] <= xe;
        y_s[0] <= ye;
        z_s[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign dx = y_s[i] >>> i;
    assign dy = x_s[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_s[i+1] <= zero_s[i];
        if (y_s[i][CW-1]) begin
          x_s[i+1] <= x_s[i] - dx;
          y_s[i+1] <= y_s[i] + dy;
          z_s[i+1] <= z_s[i] - c2p_pkg::atan_turns(i);
        end else begin
          x_s[i+1] <= x_s[i] + dx;
          y_s[i+1] <= y_s[i] - dy;
          z_s[i+1] <= z_s[i] + c2p_pkg::atan_turns(i);
        end
      end
    end
  end

  assign z_round = z_s[STEPS] + c2p_pkg::ROUND_HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_s[STEPS]) begin
        head_r[0] <= '0;
      end else begin
        head_r[0] <= z_round[ZW-1 -: c2p_pkg::HEADING_WIDTH];
      end
    end
  end

  for (genvar p = 1; p <= PAD; p++) begin : g_pad
    always_ff @(posedge clk) begin
      if (en) begin
        head_r[p] <= head_r[p-1];
      end
    end
  end

  assign heading = head_r[PAD];

endmodule
`default_nettype wire

### hdl/cartesian_to_polar.sv
// Top level of the pipelined Cartesian-to-polar converter.
//
//   Channel  Direction  Payload                Transaction
//   vec      in         vec_x, vec_y           valid && ready
//   polar    out        magnitude, heading     valid && ready
//
// One transaction is accepted every cycle while the output side takes results.
// At the default sizes the one-bit-per-stage square root is the longer path and sets the latency.
// All stages advance together; when a result waits at the output, the whole pipeline holds
// and vec.ready drops, so nothing is lost or repeated.
// Reset clears the valid bits of every stage.
`default_nettype none
module cartesian_to_polar #(
  parameter int COORD_WIDTH  = c2p_pkg::COORD_WIDTH,
  parameter int CORDIC_STEPS = c2p_pkg::CORDIC_STEPS
) (
  input  logic                       clk,
  input  logic                       rst,
  c2p_vec_if.sink                    vec,
  c2p_polar_if.source                polar
);

  localparam int SQRT_LAT   = COORD_WIDTH + 4;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int LAT        = (SQRT_LAT > CORDIC_LAT) ? SQRT_LAT : CORDIC_LAT;

  logic                          en;
  logic                          valid [0:LAT];
  logic signed [COORD_WIDTH-1:0] x;
  logic signed [COORD_WIDTH-1:0] y;

  assign en        = !valid[LAT] || polar.ready;
  assign vec.ready = en;
  assign polar.valid = valid[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (en) begin
      valid[0] <= vec.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x <= vec.vec_x;
      y <= vec.vec_y;
    end
  end

  for (genvar s = 1; s <= LAT; s++) begin : g_valid
    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s] <= 1'b0;
      end else if (en) begin
        valid[s] <= valid[s-1];
      end
    end
  end

  c2p_sqrt #(
    .W   (COORD_WIDTH),
    .PAD (LAT - SQRT_LAT)
  ) u_sqrt (
    .clk       (clk),
    .en        (en),
    .x         (x),
    .y         (y),
    .magnitude (polar.magnitude)
  );

  c2p_cordic #(
    .W     (COORD_WIDTH),
    .STEPS (CORDIC_STEPS),
    .PAD   (LAT - CORDIC_LAT)
  ) u_cordic (
    .clk     (clk),
    .en      (en),
    .x       (x),
    .y       (y),
    .heading (polar.heading)
  );

endmodule
`default_nettype wire

### hdl/c2p_check.sv
// Port-level assertions for the Cartesian-to-polar converter and their bind.
`default_nettype none
module c2p_check (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [c2p_pkg::MAG_WIDTH-1:0]       magnitude,
  input logic [c2p_pkg::HEADING_WIDTH-1:0]   heading
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("A stalled result transaction was dropped.");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(magnitude) && $stable(heading))
    else $error("A stalled result changed its payload.");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("Input accepted while the pipeline is stalled.");

  a_zero_heading: assert property (@(posedge clk) disable iff (rst)
    out_valid && magnitude == '0 |-> heading == '0)
    else $error("A zero vector produced a nonzero heading.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("A result transaction appeared right after reset.");

endmodule

bind cartesian_to_polar c2p_check u_c2p_check (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (vec.ready),
  .out_valid (polar.valid),
  .out_ready (polar.ready),
  .magnitude (polar.magnitude),
  .heading   (polar.heading)
);
`default_nettype wire
